### src/plc_pkg.sv
`default_nettype none

package plc_pkg;

	// Width of the tolerance register.
	localparam int TOL_W = 16;

	// Microcode step counter.
	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] pc_t;

	// Datapath operations selected by a control word.
	localparam logic [2:0] OP_WAIT     = 3'd0;
	localparam logic [2:0] OP_DIFF     = 3'd1;
	localparam logic [2:0] OP_SQUARE   = 3'd2;
	localparam logic [2:0] OP_RADICAND = 3'd3;
	localparam logic [2:0] OP_ROOT     = 3'd4;
	localparam logic [2:0] OP_ACCUM    = 3'd5;
	localparam logic [2:0] OP_POINT    = 3'd6;
	localparam logic [2:0] OP_EMIT     = 3'd7;

	// Sequencing conditions: fall through, jump, jump on a first vertex,
	// jump while root iterations remain.
	localparam logic [1:0] COND_NEXT  = 2'd0;
	localparam logic [1:0] COND_JUMP  = 2'd1;
	localparam logic [1:0] COND_FIRST = 2'd2;
	localparam logic [1:0] COND_LOOP  = 2'd3;

	// Step addresses.
	localparam pc_t PC_WAIT     = 3'd0;
	localparam pc_t PC_DIFF     = 3'd1;
	localparam pc_t PC_SQUARE   = 3'd2;
	localparam pc_t PC_RADICAND = 3'd3;
	localparam pc_t PC_ROOT     = 3'd4;
	localparam pc_t PC_ACCUM    = 3'd5;
	localparam pc_t PC_POINT    = 3'd6;
	localparam pc_t PC_EMIT     = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] cond;
		pc_t        target;
	} ctrl_word_t;

	// Control store: one word per step.
	function automatic ctrl_word_t ucode_rom(input pc_t pc);
		ctrl_word_t w;
		unique case (pc)
			PC_WAIT:     w = '{op: OP_WAIT,     cond: COND_FIRST, target: PC_POINT};
			PC_DIFF:     w = '{op: OP_DIFF,     cond: COND_NEXT,  target: PC_WAIT};
			PC_SQUARE:   w = '{op: OP_SQUARE,   cond: COND_NEXT,  target: PC_WAIT};
			PC_RADICAND: w = '{op: OP_RADICAND, cond: COND_NEXT,  target: PC_WAIT};
			PC_ROOT:     w = '{op: OP_ROOT,     cond: COND_LOOP,  target: PC_ROOT};
			PC_ACCUM:    w = '{op: OP_ACCUM,    cond: COND_NEXT,  target: PC_WAIT};
			PC_POINT:    w = '{op: OP_POINT,    cond: COND_NEXT,  target: PC_WAIT};
			PC_EMIT:     w = '{op: OP_EMIT,     cond: COND_JUMP,  target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### src/plc_vertex_if.sv
`default_nettype none

interface plc_vertex_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;
	logic                          final_vertex;

	modport source (output valid, output x_coord, output y_coord, output final_vertex,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input final_vertex,
		output ready);
endinterface

`default_nettype wire

### src/plc_result_if.sv
`default_nettype none

interface plc_result_if #(
	parameter int TOTAL_WIDTH = 48
);
	logic                   valid;
	logic                   ready;
	logic [TOTAL_WIDTH-1:0] total_length;
	logic                   sides_equal;
	logic                   is_closed;
	logic                   status;

	modport source (output valid, output total_length, output sides_equal,
		output is_closed, output status, input ready);
	modport sink (input valid, input total_length, input sides_equal,
		input is_closed, input status, output ready);
endinterface

`default_nettype wire

### src/polyline_length_and_shape_check.sv
// Polyline length and shape check.
// Vertices arrive as requests on the vertex channel (valid/ready), one per
// request, with final_vertex set on the last one. One result request per
// polyline leaves on the result channel: saturating total length (fixed
// point, FRAC_BITS fraction bits), the all-sides-equal flag, the closed flag
// and a status that flags fewer than two points.
// The tolerance register is written through cfg_we/cfg_wdata; write it only
// while idle, which the block does not enforce. A first vertex passes the
// point and emit steps before the next ready; a later one passes the diff,
// square, radicand, root, accumulate, point and emit steps, the restoring
// square root resolving one of its LEN_W result bits per root step. LEN_W is
// COORD_WIDTH + 1 + FRAC_BITS, capped at 32. A result shows in the cycle after
// its emit step, in an output register; the next polyline's vertices are
// accepted meanwhile, and only a second result waits for the first to leave.
// Reset clears the tolerance to 0, the polyline state and the output valid.
`default_nettype none

module polyline_length_and_shape_check #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8,
	parameter int TOTAL_WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [plc_pkg::TOL_W-1:0] cfg_wdata,
	plc_vertex_if.sink                    vertex,
	plc_result_if.source                  result
);
	import plc_pkg::*;

	localparam int ABS_W   = COORD_WIDTH + 1;
	localparam int SQF_W   = 2 * ABS_W;
	localparam int EXT_W   = 66;
	localparam int RAD_RAW = 2 * COORD_WIDTH + 2 + 2 * FRAC_BITS;
	localparam int RAD_W   = (RAD_RAW > 64) ? 64 : RAD_RAW;
	localparam int LEN_W   = RAD_W / 2;
	localparam int SUM_W   = ((TOTAL_WIDTH > LEN_W) ? TOTAL_WIDTH : LEN_W) + 1;
	localparam int CMP_W   = (LEN_W > TOL_W) ? LEN_W : TOL_W;
	localparam int SHIFT   = 2 * FRAC_BITS;

	// Sequencer state.
	pc_t        pc_q;
	ctrl_word_t ctrl;

	// Configuration and polyline state.
	logic [TOL_W-1:0]       tol_q;
	logic [COORD_WIDTH-1:0] start_x_q, start_y_q, prev_x_q, prev_y_q;
	logic [1:0]             points_q;
	logic [LEN_W-1:0]       ref_len_q;
	logic                   equal_q;
	logic [TOTAL_WIDTH-1:0] total_q;

	// Latched request and datapath working registers.
	logic [COORD_WIDTH-1:0] x_q, y_q;
	logic                   fin_q;
	logic [ABS_W-1:0]       abs_x_q, abs_y_q;
	logic [63:0]            sq_x_q, sq_y_q;
	logic [RAD_W-1:0]       rem_q, root_q, bit_q;

	// Output register.
	logic                   out_valid_q;
	logic [TOTAL_WIDTH-1:0] out_total_q;
	logic                   out_equal_q, out_closed_q, out_status_q;

	logic accept, stall, take, out_free;

	assign ctrl   = ucode_rom(pc_q);
	assign accept = vertex.valid && vertex.ready;

	assign vertex.ready        = (ctrl.op == OP_WAIT);
	assign result.valid        = out_valid_q;
	assign result.total_length = out_total_q;
	assign result.sides_equal  = out_equal_q;
	assign result.is_closed    = out_closed_q;
	assign result.status       = out_status_q;

	assign out_free = !out_valid_q || result.ready;

	// Coordinate differences as magnitudes.
	logic signed [ABS_W-1:0] dx, dy;
	logic [ABS_W-1:0]        abs_x, abs_y;
	always_comb begin
		dx    = $signed({x_q[COORD_WIDTH-1], x_q}) - $signed({prev_x_q[COORD_WIDTH-1], prev_x_q});
		dy    = $signed({y_q[COORD_WIDTH-1], y_q}) - $signed({prev_y_q[COORD_WIDTH-1], prev_y_q});
		abs_x = dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
		abs_y = dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
	end

	// Squares, saturating at 64 bits once a magnitude needs more than 32 bits.
	logic [SQF_W-1:0] sqf_x, sqf_y;
	logic [EXT_W-1:0] sqe_x, sqe_y;
	logic [63:0]      sq_x, sq_y;
	always_comb begin
		sqf_x = SQF_W'(abs_x_q) * SQF_W'(abs_x_q);
		sqf_y = SQF_W'(abs_y_q) * SQF_W'(abs_y_q);
		sqe_x = EXT_W'(sqf_x);
		sqe_y = EXT_W'(sqf_y);
		sq_x  = (EXT_W'(abs_x_q) > EXT_W'(33'h0_FFFF_FFFF)) ? '1 : sqe_x[63:0];
		sq_y  = (EXT_W'(abs_y_q) > EXT_W'(33'h0_FFFF_FFFF)) ? '1 : sqe_y[63:0];
	end

	// Radicand: saturating sum, then the fraction shift with saturation.
	logic [64:0] sq_sum;
	logic [63:0] sum_sat, rad64;
	always_comb begin
		sq_sum  = {1'b0, sq_x_q} + {1'b0, sq_y_q};
		sum_sat = sq_sum[64] ? '1 : sq_sum[63:0];
		rad64   = ((sum_sat >> (64 - SHIFT)) != 64'd0) ? '1 : (sum_sat << SHIFT);
	end

	// One restoring square-root step.
	logic [RAD_W:0]   trial;
	logic             fits;
	always_comb begin
		trial = {1'b0, root_q} + {1'b0, bit_q};
		fits  = {1'b0, rem_q} >= trial;
	end

	// Length bookkeeping: tolerance check and saturating total.
	logic [LEN_W-1:0] seg_len, len_diff;
	logic [SUM_W-1:0] tot_sum;
	logic             too_far, tot_over;
	always_comb begin
		seg_len  = root_q[LEN_W-1:0];
		len_diff = (seg_len >= ref_len_q) ? (seg_len - ref_len_q) : (ref_len_q - seg_len);
		too_far  = CMP_W'(len_diff) > CMP_W'(tol_q);
		tot_sum  = SUM_W'(total_q) + SUM_W'(seg_len);
		tot_over = tot_sum > SUM_W'({TOTAL_WIDTH{1'b1}});
	end

	// Step sequencing.
	always_comb begin
		stall = ((ctrl.op == OP_WAIT) && !accept) ||
			((ctrl.op == OP_EMIT) && fin_q && !out_free);
		take  = (ctrl.cond == COND_JUMP) ||
			((ctrl.cond == COND_FIRST) && (points_q == 2'd0)) ||
			((ctrl.cond == COND_LOOP) && !bit_q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (!stall) begin
			pc_q <= take ? ctrl.target : pc_q + PC_W'(1);
		end
	end

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Output register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_EMIT) && fin_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_EMIT) && fin_q && out_free) begin
			if (points_q != 2'd2) begin
				out_total_q  <= '0;
				out_equal_q  <= 1'b1;
				out_closed_q <= 1'b0;
				out_status_q <= 1'b1;
			end else begin
				out_total_q  <= total_q;
				out_equal_q  <= equal_q;
				out_closed_q <= (start_x_q == x_q) && (start_y_q == y_q);
				out_status_q <= 1'b0;
			end
		end
	end

	// Polyline state, updated by the accumulate, point and emit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			points_q  <= 2'd0;
			ref_len_q <= '0;
			equal_q   <= 1'b1;
			total_q   <= '0;
		end else begin
			unique case (ctrl.op)
				OP_ACCUM: begin
					if (points_q == 2'd1) begin
						ref_len_q <= seg_len;
					end else if (too_far) begin
						equal_q <= 1'b0;
					end
					total_q  <= tot_over ? '1 : tot_sum[TOTAL_WIDTH-1:0];
					points_q <= 2'd2;
				end
				OP_POINT: begin
					if (points_q == 2'd0) begin
						start_x_q <= x_q;
						start_y_q <= y_q;
						points_q  <= 2'd1;
					end
					prev_x_q <= x_q;
					prev_y_q <= y_q;
				end
				OP_EMIT: begin
					if (fin_q && out_free) begin
						start_x_q <= '0;
						start_y_q <= '0;
						prev_x_q  <= '0;
						prev_y_q  <= '0;
						points_q  <= 2'd0;
						ref_len_q <= '0;
						equal_q   <= 1'b1;
						total_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath working registers.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_WAIT: begin
				if (accept) begin
					x_q   <= vertex.x_coord;
					y_q   <= vertex.y_coord;
					fin_q <= vertex.final_vertex;
				end
			end
			OP_DIFF: begin
				abs_x_q <= abs_x;
				abs_y_q <= abs_y;
			end
			OP_SQUARE: begin
				sq_x_q <= sq_x;
				sq_y_q <= sq_y;
			end
			OP_RADICAND: begin
				rem_q  <= rad64[RAD_W-1:0];
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end
			OP_ROOT: begin
				if (fits) begin
					rem_q  <= rem_q - trial[RAD_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	// After a vertex is accepted, ready drops while that vertex is in work.
	a_single_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !vertex.ready)
		else $error("vertex accepted while previous one still in work");

	// The point count saturates at two.
	a_points_range: assert property (@(posedge clk) disable iff (!arst_n)
		points_q != 2'd3)
		else $error("point count out of range");

	// The square-root step mask stays a single bit through the iterations.
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_ROOT) |-> $onehot(bit_q))
		else $error("square root step mask corrupted");

	// A short polyline reports a zero total with the equal flag set.
	a_short_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status) |->
			((result.total_length == '0) && result.sides_equal && !result.is_closed))
		else $error("short polyline result malformed");

endmodule

`default_nettype wire
